// ===== hw/rtl/deadline_timer_queue_assert.svh =====
// Assertion macros for the deadline timer queue.
// Included by the top level; relies on nothing else.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DTQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dtq_pkg.sv =====
// Shared types, codes and helpers of the deadline timer queue.
// No dependencies; imported by the front end, the engine and the top level.
package dtq_pkg;

   localparam int TIME_W = 48;
   localparam int DUR_W  = 31;

   // Operation codes after classification by the front end.
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_CREATE  = 3'd1;
   localparam logic [2:0] OP_SET     = 3'd2;
   localparam logic [2:0] OP_SET_AT  = 3'd3;
   localparam logic [2:0] OP_RUN     = 3'd4;
   localparam logic [2:0] OP_FOREVER = 3'd5;
   localparam logic [2:0] OP_RESET   = 3'd6;
   localparam logic [2:0] OP_NOP     = 3'd7;

   // Result kinds.
   localparam logic [1:0] KIND_OK   = 2'd0;
   localparam logic [1:0] KIND_ERR  = 2'd1;
   localparam logic [1:0] KIND_WAKE = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // Timer modes.
   localparam logic [1:0] MODE_ONESHOT = 2'd0;
   localparam logic [1:0] MODE_RUN     = 2'd1;
   localparam logic [1:0] MODE_FOREVER = 2'd2;

   typedef struct packed {
      logic [2:0]        op;
      logic [3:0]        id;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] when;
      logic [DUR_W-1:0]  dur;
      logic [DUR_W-1:0]  lim;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic [8:0] qlen;
   } stat_type;

   // Saturating time addition.
   function automatic logic [TIME_W-1:0] time_add(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/dtq_if.sv =====
// Request and response channel interfaces of the deadline timer queue.
// No dependencies.
interface dtq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [3:0]  timer_id;
   logic [47:0] now_ms;
   logic [47:0] when_ms;
   logic [30:0] duration_ms;
   logic [30:0] timeout_limit;

   modport source (output valid, func, timer_id, now_ms, when_ms, duration_ms,
                   timeout_limit, input ready);
   modport sink   (input valid, func, timer_id, now_ms, when_ms, duration_ms,
                   timeout_limit, output ready);
endinterface

interface dtq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  wake_id;
   logic [30:0] next_timeout;
   logic [5:0]  wake_count;
   logic        last_of_run;

   modport source (output valid, kind, wake_id, next_timeout, wake_count,
                   last_of_run, input ready);
   modport sink   (input valid, kind, wake_id, next_timeout, wake_count,
                   last_of_run, output ready);
endinterface

// ===== hw/rtl/dtq_front.sv =====
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on dtq_pkg and dtq_req_if.
module dtq_front
   import dtq_pkg::*;
#(
   parameter int TIMERS = 16
) (
   input  logic     clock,
   input  logic     reset,
   dtq_req_if.sink  req_ch,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_pop
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic [1:0] count_ff, count_in;
   cmd_type    classified;
   logic       push;

   // Requests other than ticks with an id beyond the bank become no-operations.
   always_comb begin
      classified.op   = req_ch.func;
      classified.id   = req_ch.timer_id;
      classified.now  = req_ch.now_ms;
      classified.when = req_ch.when_ms;
      classified.dur  = req_ch.duration_ms;
      classified.lim  = req_ch.timeout_limit;
      if (req_ch.func != OP_TICK && {5'd0, req_ch.timer_id} >= 9'(TIMERS)) begin
         classified.op = OP_NOP;
      end
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push      = req_ch.valid && req_ch.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[0];

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (cmd_pop && cmd_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = classified;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/dtq_engine.sv =====
// Back end: executes commands and ticks against the sorted timer queue.
// Depends on dtq_pkg and dtq_rsp_if.
module dtq_engine
   import dtq_pkg::*;
#(
   parameter int TIMERS    = 16,
   parameter int MAX_WAKES = 63
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   dtq_rsp_if.source rsp_ch,
   output stat_type  stat
);

   localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int LW = $clog2(TIMERS + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_UNLINK = 4'd1;
   localparam logic [3:0] ST_INSERT = 4'd2;
   localparam logic [3:0] ST_RESP   = 4'd3;
   localparam logic [3:0] ST_HEAD   = 4'd4;
   localparam logic [3:0] ST_POP    = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_RWAKE  = 4'd7;
   localparam logic [3:0] ST_MUL    = 4'd8;
   localparam logic [3:0] ST_ARM    = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   // Per-timer state.
   logic [TIME_W-1:0] dl_ff    [TIMERS];
   logic [TIME_W-1:0] dl_in    [TIMERS];
   logic [DUR_W-1:0]  dur_ff   [TIMERS];
   logic [DUR_W-1:0]  dur_in   [TIMERS];
   logic [1:0]        mode_ff  [TIMERS];
   logic [1:0]        mode_in  [TIMERS];
   logic [TIME_W-1:0] start_ff [TIMERS];
   logic [TIME_W-1:0] start_in [TIMERS];
   logic [31:0]       woken_ff [TIMERS];
   logic [31:0]       woken_in [TIMERS];
   logic [IW-1:0]     qo_ff    [TIMERS];
   logic [IW-1:0]     qo_in    [TIMERS];
   logic [LW-1:0]     len_ff, len_in;

   // Sequencer state.
   logic [3:0]        st_ff, st_in;
   cmd_type           cmd_ff, cmd_in;
   logic [1:0]        kind_ff, kind_in;
   logic [IW-1:0]     tgt_ff, tgt_in;
   logic [LW-1:0]     p_ff, p_in;
   logic [LW-1:0]     pops_ff, pops_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [TIME_W-1:0] when_ff, when_in;
   logic [49:0]       num_ff, num_in;
   logic [49:0]       quo_ff, quo_in;
   logic [32:0]       rem_ff, rem_in;
   logic [31:0]       dv_ff, dv_in;
   logic [5:0]        step_ff, step_in;
   logic [63:0]       prod_ff, prod_in;

   // Output register.
   logic              ov_ff, ov_in;
   logic [1:0]        ok_ff, ok_in;
   logic [3:0]        oid_ff, oid_in;
   logic [DUR_W-1:0]  ont_ff, ont_in;
   logic [5:0]        ocnt_ff, ocnt_in;
   logic              olast_ff, olast_in;

   logic              can_emit;
   logic [IW-1:0]     cid;
   logic [DUR_W-1:0]  d_cmd, d_tgt;
   logic [IW-1:0]     head;
   logic [TIME_W-1:0] diff;
   logic [32:0]       rs;
   logic [31:0]       times;
   logic [TIME_W-1:0] newdl;
   logic [TIME_W:0]   arm_sum;
   logic [TIME_W-1:0] at;

   assign can_emit = !ov_ff || rsp_ch.ready;
   assign cid      = IW'(cmd.id);
   assign d_cmd    = dur_ff[cid];
   assign d_tgt    = dur_ff[tgt_ff];
   assign head     = qo_ff[0];
   assign times    = (quo_ff[49:32] != 18'd0) ? 32'hFFFF_FFFF : quo_ff[31:0];
   assign rs       = {rem_ff[31:0], num_ff[49]};
   assign arm_sum  = {1'b0, start_ff[tgt_ff]} + {1'b0, prod_ff[TIME_W-1:0]};

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.kind         = ok_ff;
   assign rsp_ch.wake_id      = oid_ff;
   assign rsp_ch.next_timeout = ont_ff;
   assign rsp_ch.wake_count   = ocnt_ff;
   assign rsp_ch.last_of_run  = olast_ff;

   assign stat.busy = (st_ff != ST_IDLE);
   assign stat.qlen = 9'(len_ff);

   always_comb begin
      dl_in    = dl_ff;
      dur_in   = dur_ff;
      mode_in  = mode_ff;
      start_in = start_ff;
      woken_in = woken_ff;
      qo_in    = qo_ff;
      len_in   = len_ff;
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      kind_in  = kind_ff;
      tgt_in   = tgt_ff;
      p_in     = p_ff;
      pops_in  = pops_ff;
      cnt_in   = cnt_ff;
      when_in  = when_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      ov_in    = ov_ff && !rsp_ch.ready;
      ok_in    = ok_ff;
      oid_in   = oid_ff;
      ont_in   = ont_ff;
      ocnt_in  = ocnt_ff;
      olast_in = olast_ff;
      cmd_pop  = 1'b0;
      diff     = '0;
      newdl    = '0;
      at       = '0;

      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               tgt_in  = cid;
               p_in    = '0;
               kind_in = KIND_OK;
               newdl   = time_add(cmd.now, TIME_W'(d_cmd));
               when_in = newdl;
               case (cmd.op)
                  OP_TICK: begin
                     cnt_in  = '0;
                     pops_in = '0;
                     st_in   = ST_HEAD;
                  end
                  OP_CREATE: begin
                     dl_in[cid]    = '0;
                     mode_in[cid]  = MODE_ONESHOT;
                     start_in[cid] = '0;
                     woken_in[cid] = '0;
                     dur_in[cid]   = cmd.dur;
                     st_in         = ST_UNLINK;
                  end
                  OP_SET, OP_RUN, OP_FOREVER: begin
                     if (d_cmd == '0) begin
                        kind_in = KIND_ERR;
                        st_in   = ST_RESP;
                     end else begin
                        dl_in[cid] = newdl;
                        st_in      = ST_UNLINK;
                        if (cmd.op == OP_RUN) begin
                           mode_in[cid]  = MODE_RUN;
                           start_in[cid] = cmd.now;
                           woken_in[cid] = '0;
                        end else if (cmd.op == OP_FOREVER) begin
                           mode_in[cid]  = MODE_FOREVER;
                           start_in[cid] = '0;
                        end else begin
                           mode_in[cid]  = MODE_ONESHOT;
                           start_in[cid] = '0;
                        end
                     end
                  end
                  OP_SET_AT: begin
                     dl_in[cid]    = cmd.when;
                     when_in       = cmd.when;
                     mode_in[cid]  = MODE_ONESHOT;
                     start_in[cid] = '0;
                     st_in         = ST_UNLINK;
                  end
                  OP_RESET: begin
                     mode_in[cid]  = MODE_ONESHOT;
                     start_in[cid] = '0;
                     st_in         = ST_UNLINK;
                  end
                  default: begin
                     st_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_UNLINK: begin
            if (p_ff < len_ff && qo_ff[p_ff[IW-1:0]] != tgt_ff) begin
               p_in = p_ff + LW'(1);
            end else begin
               if (p_ff < len_ff) begin
                  for (int j = 0; j < TIMERS - 1; j++) begin
                     if (j >= int'(p_ff)) begin
                        qo_in[j] = qo_ff[j + 1];
                     end
                  end
                  len_in = len_ff - LW'(1);
               end
               p_in = '0;
               if (cmd_ff.op == OP_CREATE || cmd_ff.op == OP_RESET) begin
                  st_in = ST_RESP;
               end else begin
                  st_in = ST_INSERT;
               end
            end
         end

         ST_INSERT: begin
            if (p_ff < len_ff && dl_ff[qo_ff[p_ff[IW-1:0]]] <= when_ff) begin
               p_in = p_ff + LW'(1);
            end else begin
               for (int j = 1; j < TIMERS; j++) begin
                  if (j > int'(p_ff)) begin
                     qo_in[j] = qo_ff[j - 1];
                  end
               end
               qo_in[p_ff[IW-1:0]] = tgt_ff;
               len_in = len_ff + LW'(1);
               st_in  = (cmd_ff.op == OP_TICK) ? ST_HEAD : ST_RESP;
            end
         end

         ST_RESP: begin
            if (can_emit) begin
               ov_in    = 1'b1;
               ok_in    = kind_ff;
               oid_in   = cmd_ff.id;
               ont_in   = '0;
               ocnt_in  = '0;
               olast_in = 1'b1;
               st_in    = ST_IDLE;
            end
         end

         ST_HEAD: begin
            tgt_in = head;
            if (len_ff != '0 && pops_ff < LW'(TIMERS) && cnt_ff < 6'(MAX_WAKES)
                && dl_ff[head] <= cmd_ff.now) begin
               if (mode_ff[head] == MODE_RUN && dur_ff[head] != '0) begin
                  diff    = (cmd_ff.now >= start_ff[head]) ?
                            cmd_ff.now - start_ff[head] : '0;
                  num_in  = {1'b0, diff, 1'b0} + 50'(dur_ff[head]);
                  dv_in   = {dur_ff[head], 1'b0};
                  rem_in  = '0;
                  quo_in  = '0;
                  step_in = '0;
                  st_in   = ST_DIV;
               end else begin
                  st_in = ST_POP;
               end
            end else begin
               st_in = ST_DONE;
            end
         end

         ST_POP: begin
            if (can_emit) begin
               for (int j = 0; j < TIMERS - 1; j++) begin
                  qo_in[j] = qo_ff[j + 1];
               end
               len_in   = len_ff - LW'(1);
               pops_in  = pops_ff + LW'(1);
               cnt_in   = cnt_ff + 6'd1;
               ov_in    = 1'b1;
               ok_in    = KIND_WAKE;
               oid_in   = 4'(tgt_ff);
               ont_in   = '0;
               ocnt_in  = cnt_ff + 6'd1;
               olast_in = 1'b0;
               p_in     = '0;
               if (mode_ff[tgt_ff] == MODE_FOREVER && d_tgt != '0) begin
                  newdl          = time_add(cmd_ff.now, TIME_W'(d_tgt));
                  dl_in[tgt_ff]  = newdl;
                  when_in        = newdl;
                  st_in          = ST_INSERT;
               end else begin
                  dl_in[tgt_ff]    = cmd_ff.now;
                  mode_in[tgt_ff]  = MODE_ONESHOT;
                  start_in[tgt_ff] = '0;
                  st_in            = ST_HEAD;
               end
            end
         end

         ST_DIV: begin
            num_in  = {num_ff[48:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (rs >= {1'b0, dv_ff}) begin
               rem_in = rs - {1'b0, dv_ff};
               quo_in = {quo_ff[48:0], 1'b1};
            end else begin
               rem_in = rs;
               quo_in = {quo_ff[48:0], 1'b0};
            end
            if (step_ff == 6'd49) begin
               st_in = ST_RWAKE;
            end
         end

         ST_RWAKE: begin
            if (woken_ff[tgt_ff] < times && cnt_ff < 6'(MAX_WAKES)) begin
               if (can_emit) begin
                  woken_in[tgt_ff] = woken_ff[tgt_ff] + 32'd1;
                  cnt_in   = cnt_ff + 6'd1;
                  ov_in    = 1'b1;
                  ok_in    = KIND_WAKE;
                  oid_in   = 4'(tgt_ff);
                  ont_in   = '0;
                  ocnt_in  = cnt_ff + 6'd1;
                  olast_in = 1'b0;
               end
            end else if (woken_ff[tgt_ff] < times) begin
               st_in = ST_DONE;
            end else begin
               st_in = ST_MUL;
            end
         end

         ST_MUL: begin
            prod_in = ({1'b0, woken_ff[tgt_ff]} + 33'd1) * d_tgt;
            st_in   = ST_ARM;
         end

         ST_ARM: begin
            if (prod_ff[63:TIME_W] != '0 || arm_sum[TIME_W]) begin
               newdl = {TIME_W{1'b1}};
            end else begin
               newdl = arm_sum[TIME_W-1:0];
            end
            dl_in[tgt_ff] = newdl;
            when_in       = newdl;
            for (int j = 0; j < TIMERS - 1; j++) begin
               qo_in[j] = qo_ff[j + 1];
            end
            len_in  = len_ff - LW'(1);
            pops_in = pops_ff + LW'(1);
            p_in    = '0;
            st_in   = ST_INSERT;
         end

         ST_DONE: begin
            if (can_emit) begin
               ont_in = cmd_ff.lim;
               if (len_ff != '0) begin
                  at = (dl_ff[head] > cmd_ff.now) ? dl_ff[head] - cmd_ff.now : '0;
                  if (at < TIME_W'(cmd_ff.lim)) begin
                     ont_in = at[DUR_W-1:0];
                  end
               end
               ov_in    = 1'b1;
               ok_in    = KIND_DONE;
               oid_in   = '0;
               ocnt_in  = cnt_ff;
               olast_in = 1'b1;
               st_in    = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      qo_ff   <= qo_in;
      cmd_ff  <= cmd_in;
      kind_ff <= kind_in;
      tgt_ff  <= tgt_in;
      p_ff    <= p_in;
      pops_ff <= pops_in;
      cnt_ff  <= cnt_in;
      when_ff <= when_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      ok_ff    <= ok_in;
      oid_ff   <= oid_in;
      ont_ff   <= ont_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
      if (reset) begin
         for (int j = 0; j < TIMERS; j++) begin
            dl_ff[j]    <= '0;
            dur_ff[j]   <= '0;
            mode_ff[j]  <= MODE_ONESHOT;
            start_ff[j] <= '0;
            woken_ff[j] <= '0;
         end
         len_ff <= '0;
         st_ff  <= ST_IDLE;
         ov_ff  <= 1'b0;
      end else begin
         dl_ff    <= dl_in;
         dur_ff   <= dur_in;
         mode_ff  <= mode_in;
         start_ff <= start_in;
         woken_ff <= woken_in;
         len_ff   <= len_in;
         st_ff    <= st_in;
         ov_ff    <= ov_in;
      end
   end

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: front end, execution engine, checks.
// Depends on dtq_pkg, dtq_if, dtq_front, dtq_engine and the assertion header.
//
// A bank of TIMERS timers kept in a queue sorted by deadline, ties in arrival
// order. A command (create, set, set_at, run, forever, reset) returns one
// result; a tick returns one wake transfer per expired timer period, up to
// MAX_WAKES, then a done transfer with the time to the next deadline, capped
// by the given limit. Requests are queued two deep in the front end and run
// one at a time in the engine, which picks a request up from the front end
// while idle. In the engine a command scans the queue for the timer and
// unlinks it; all but create and reset then scan for its new place and
// insert it, and it responds. A refused command goes straight to its
// response. A tick checks the head and pops each expired one-shot timer; a
// forever timer is rescheduled by a reinsertion scan. A run-mode timer goes
// through the head check, a bit-serial catch-up divider, one wake per expired
// period, the final wake check, the re-arm multiply and the add, and its
// reinsertion scan.
// Results leave through an output register, so a stalled response holds the
// engine only when it must emit.
`include "deadline_timer_queue_assert.svh"

module deadline_timer_queue
   import dtq_pkg::*;
#(
   parameter int TIMERS    = 16,
   parameter int MAX_WAKES = 63
) (
   input  logic      clock,
   input  logic      reset,
   dtq_req_if.sink   req_ch,
   dtq_rsp_if.source rsp_ch
);

   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_pop;
   stat_type stat;
   logic     rsp_done;
   logic     rsp_done_ok;
   logic     rsp_wake;
   logic     rsp_wake_ok;
   logic     qlen_ok;

   // The front end classifies each request transfer and buffers it.
   dtq_front #(
      .TIMERS (TIMERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // The engine owns all timer state and the sorted queue.
   dtq_engine #(
      .TIMERS    (TIMERS),
      .MAX_WAKES (MAX_WAKES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch),
      .stat      (stat)
   );

   assign rsp_done    = rsp_ch.valid && rsp_ch.kind == KIND_DONE;
   assign rsp_done_ok = rsp_ch.last_of_run && rsp_ch.wake_id == 4'd0;
   assign rsp_wake    = rsp_ch.valid && rsp_ch.kind == KIND_WAKE;
   assign rsp_wake_ok = !rsp_ch.last_of_run && rsp_ch.wake_count != 6'd0
                        && rsp_ch.next_timeout == 31'd0;
   assign qlen_ok     = stat.qlen <= 9'(TIMERS);

   // A done result always ends the run and names no timer.
   `DTQ_ASSERT_SAME(a_done_last, clock, reset, rsp_done, rsp_done_ok, "done result malformed")
   // A wake is never last, carries an ordinal and no timeout.
   `DTQ_ASSERT_SAME(a_wake_form, clock, reset, rsp_wake, rsp_wake_ok, "wake result malformed")
   // The queue never holds more timers than the bank has.
   `DTQ_ASSERT_SAME(a_qlen, clock, reset, 1'b1, qlen_ok, "queue overflow")
   // Once the engine is idle it stays idle until a request is buffered.
   `DTQ_ASSERT_NEXT(a_idle_hold, clock, reset, !stat.busy && !cmd_valid, !stat.busy, "engine left idle")

endmodule
